FILE: sv/tst_pkg.sv
// Shared types and constants for the transpose search table.
`default_nettype none
package tst_pkg;

  localparam int KEY_W = 32;
  localparam int POS_W = 5;

  typedef enum logic [1:0] {
    CMD_SEARCH = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] content;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             table_full;
  } out_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] content;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic pass;
  } cell_stat_t;

endpackage
`default_nettype wire

FILE: sv/tst_cell.sv
// One table slot: holds an entry, compares the probe token and swaps with its neighbors.
`default_nettype none
module tst_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                tok_in,
  input  wire logic [CW-1:0]       count,
  input  wire tst_pkg::in_t        probe,
  input  wire tst_pkg::entry_t     left,
  input  wire tst_pkg::entry_t     right,
  input  wire logic                right_hit,
  output tst_pkg::entry_t          entry,
  output tst_pkg::cell_stat_t      stat
);

  logic             tok_r;
  tst_pkg::entry_t  entry_r;
  tst_pkg::entry_t  entry_nxt;
  logic             vld;
  logic             match;
  logic             hit;
  logic             miss;
  logic             is_ins;

  assign vld    = CW'(IDX) < count;
  assign match  = probe.key == entry_r.key;
  assign hit    = tok_r & vld & match;
  assign miss   = tok_r & ~vld;
  assign is_ins = probe.cmd == tst_pkg::CMD_INSERT;

  always_comb begin
    entry_nxt = entry_r;
    if (right_hit) begin
      // right neighbor moves up into this slot
      entry_nxt.key     = right.key;
      entry_nxt.content = is_ins ? probe.content : right.content;
    end else if (hit) begin
      if (IDX > 0) begin
        entry_nxt = left;
      end else if (is_ins) begin
        entry_nxt.content = probe.content;
      end
    end else if (miss && is_ins) begin
      entry_nxt.key     = probe.key;
      entry_nxt.content = probe.content;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry     = entry_r;
  assign stat.hit  = hit;
  assign stat.pass = tok_r & vld & ~match;

endmodule
`default_nettype wire

FILE: sv/tst_ctrl.sv
// Command sequencer: entry count, scan step counter, result and output register.
`default_nettype none
module tst_ctrl #(
  parameter int DEPTH = 31,
  parameter int CW    = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tst_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tst_pkg::out_t      out_data,
  input  wire logic          any_hit,
  output logic               start,
  output tst_pkg::in_t       probe,
  output logic [CW-1:0]      count
);

  tst_pkg::state_e state_r, state_nxt;
  tst_pkg::in_t    probe_r, probe_nxt;
  tst_pkg::out_t   res_r, res_nxt;
  tst_pkg::out_t   out_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r;
  logic            in_acc;
  logic            is_scan_cmd;
  logic            resolved;
  logic            is_full;
  logic            is_ins;
  logic            out_free;

  assign in_acc      = in_valid & ~in_stall;
  assign is_scan_cmd = in_data.cmd == tst_pkg::CMD_SEARCH ||
                       in_data.cmd == tst_pkg::CMD_INSERT;
  assign resolved    = any_hit || cnt_r == count_r;
  assign is_full     = count_r == CW'(DEPTH);
  assign is_ins      = probe_r.cmd == tst_pkg::CMD_INSERT;
  assign out_free    = ~out_valid_r | ~out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tst_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = is_scan_cmd ? tst_pkg::ST_SCAN : tst_pkg::ST_DONE;
        end
      end
      tst_pkg::ST_SCAN: begin
        if (resolved) state_nxt = tst_pkg::ST_DONE;
      end
      tst_pkg::ST_DONE: begin
        if (out_free) state_nxt = tst_pkg::ST_IDLE;
      end
      default: state_nxt = tst_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall  = 1'b1;
    start     = 1'b0;
    probe_nxt = probe_r;
    res_nxt   = res_r;
    count_nxt = count_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      tst_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          probe_nxt = in_data;
          res_nxt   = '0;
          cnt_nxt   = '0;
          start     = is_scan_cmd;
          if (in_data.cmd == tst_pkg::CMD_CLEAR) count_nxt = '0;
        end
      end
      tst_pkg::ST_SCAN: begin
        if (resolved) begin
          res_nxt.found = any_hit;
          if (any_hit) begin
            res_nxt.position = (cnt_r == '0) ? '0 : tst_pkg::POS_W'(cnt_r - 1'b1);
          end else begin
            res_nxt.position = tst_pkg::POS_W'(count_r);
          end
          res_nxt.table_full = ~any_hit & is_ins & is_full;
          if (~any_hit && is_ins && !is_full) count_nxt = CW'(count_r + 1'b1);
        end else begin
          cnt_nxt = CW'(cnt_r + 1'b1);
        end
      end
      tst_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tst_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == tst_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    res_r   <= res_nxt;
    cnt_r   <= cnt_nxt;
    if (state_r == tst_pkg::ST_DONE && out_free) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign probe     = probe_r;
  assign count     = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tst_pkg::ST_SCAN |-> cnt_r <= count_r)
    else $error("scan step ran past entry count");

  a_resolve_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tst_pkg::ST_SCAN && resolved |=> state_r == tst_pkg::ST_DONE)
    else $error("resolved scan did not finish");

  a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.found && out_r.table_full))
    else $error("hit word flagged full");

endmodule
`default_nettype wire

FILE: sv/transpose_search_table_top.sv
// Top level: sequencer plus a chain of slot cells that a probe token walks one slot a cycle.
// Sequence: a search or insert token visits the slots in order until a hit or the entry count
//   ends the scan, then the result is loaded into the output word; clear and unused skip the scan.
// Flow: one command at a time; a new command is accepted only after the last result word is
//   loaded and the sequencer is back in idle.
// Reset: synchronous active-low; empties the table (entry count zero), drops token and output.
`default_nettype none
module transpose_search_table_top #(
  parameter int TABLE_SLOTS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tst_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tst_pkg::out_t      out_data
);

  localparam int DEPTH = TABLE_SLOTS - 1;
  localparam int CW    = $clog2(TABLE_SLOTS);

  logic                start;
  tst_pkg::in_t        probe;
  logic [CW-1:0]       count;
  logic [DEPTH-1:0]    hit_vec;
  logic                any_hit;
  tst_pkg::entry_t     ent  [DEPTH];
  tst_pkg::cell_stat_t stat [DEPTH];

  assign any_hit = |hit_vec;

  tst_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .any_hit   (any_hit),
    .start     (start),
    .probe     (probe),
    .count     (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            tok_in;
    tst_pkg::entry_t left;
    tst_pkg::entry_t right;
    logic            right_hit;

    if (i == 0) begin : g_first
      assign tok_in = start;
      assign left   = ent[i];
    end else begin : g_mid
      assign tok_in = stat[i-1].pass;
      assign left   = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right     = ent[i];
      assign right_hit = 1'b0;
    end else begin : g_inner
      assign right     = ent[i+1];
      assign right_hit = stat[i+1].hit;
    end

    tst_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_in    (tok_in),
      .count     (count),
      .probe     (probe),
      .left      (left),
      .right     (right),
      .right_hit (right_hit),
      .entry     (ent[i]),
      .stat      (stat[i])
    );

    assign hit_vec[i] = stat[i].hit;
  end

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one slot matched");

endmodule
`default_nettype wire

FILE: tb/tst_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the transpose search table: tracks the table, predicts and compares words.
module tst_result_checker #(
  parameter int TABLE_SLOTS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_stall,
  input  wire tst_pkg::in_t in_data,
  input  wire logic         out_valid,
  input  wire logic         out_stall,
  input  wire tst_pkg::out_t out_data,
  output int                fail_count,
  output int                waiting,
  output int                checked,
  output int                hits,
  output int                refused
);

  localparam int DEPTH = TABLE_SLOTS - 1;
  localparam int SHOW_LIMIT = 10;

  logic signed [tst_pkg::KEY_W-1:0] slot_key     [DEPTH];
  logic signed [tst_pkg::KEY_W-1:0] slot_content [DEPTH];
  int            fill = 0;
  tst_pkg::out_t expected_q [$];
  int            n_fail = 0;
  int            n_checked = 0;
  int            n_hits = 0;
  int            n_refused = 0;

  // Search from slot 0, move a hit one slot forward, then apply the command.
  function automatic tst_pkg::out_t lookup_and_update(input tst_pkg::in_t w);
    tst_pkg::out_t                    res;
    int                               hit_at;
    int                               slot;
    logic signed [tst_pkg::KEY_W-1:0] tmp_key;
    logic signed [tst_pkg::KEY_W-1:0] moved_content;
    res = '0;
    hit_at = -1;
    slot = 0;
    case (w.cmd) inside
      tst_pkg::CMD_SEARCH, tst_pkg::CMD_INSERT: begin
        for (int i = 0; i < fill; i++) begin
          if (hit_at < 0 && slot_key[i] == w.key) hit_at = i;
        end
        if (hit_at >= 0) begin
          slot = hit_at;
          if (hit_at > 0) begin
            tmp_key = slot_key[hit_at];
            moved_content = slot_content[hit_at];
            slot_key[hit_at] = slot_key[hit_at-1];
            slot_content[hit_at] = slot_content[hit_at-1];
            slot_key[hit_at-1] = tmp_key;
            slot_content[hit_at-1] = moved_content;
            slot = hit_at - 1;
          end
          res.found = 1'b1;
          res.position = slot[tst_pkg::POS_W-1:0];
          if (w.cmd == tst_pkg::CMD_INSERT) slot_content[slot] = w.content;
        end else begin
          res.position = fill[tst_pkg::POS_W-1:0];
          if (w.cmd == tst_pkg::CMD_INSERT) begin
            if (fill >= DEPTH) begin
              res.table_full = 1'b1;
            end else begin
              slot_key[fill] = w.key;
              slot_content[fill] = w.content;
              fill++;
            end
          end
        end
      end
      tst_pkg::CMD_CLEAR: begin
        fill = 0;
      end
      default: begin
        // unused command: drop it, result stays all zero
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    tst_pkg::out_t want;
    tst_pkg::out_t got;
    if (!rst_n) begin
      fill = 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= SHOW_LIMIT)
            $display("unexpected result word: found=%0d position=%0d table_full=%0d",
                     got.found, got.position, got.table_full);
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (got.found !== want.found || got.position !== want.position ||
              got.table_full !== want.table_full) begin
            n_fail++;
            if (n_fail <= SHOW_LIMIT)
              $display("mismatch on word %0d: expected found=%0d position=%0d full=%0d,%s",
                       n_checked, want.found, want.position, want.table_full,
                       $sformatf(" got found=%0d position=%0d full=%0d",
                                 got.found, got.position, got.table_full));
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = lookup_and_update(in_data);
        expected_q.push_back(want);
        if (want.found) n_hits++;
        if (want.table_full) n_refused++;
      end
    end
    fail_count <= n_fail;
    waiting    <= expected_q.size();
    checked    <= n_checked;
    hits       <= n_hits;
    refused    <= n_refused;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, command stimulus, output stall control and the verdict.
module tb;

  localparam int TABLE_SLOTS = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TARGET_ITEMS = 1050;
  localparam int IDLE_PCT = 7;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT = 250;
  localparam int QUIET_FROM = 450;
  localparam int QUIET_TO = 700;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  tst_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  tst_pkg::out_t out_data;

  int fail_count;
  int waiting;
  int checked;
  int hits;
  int refused;
  int sent = 0;
  bit idle_on = 1'b1;
  bit hold_done = 1'b0;

  transpose_search_table_top #(.TABLE_SLOTS(TABLE_SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  tst_result_checker #(.TABLE_SLOTS(TABLE_SLOTS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .waiting    (waiting),
    .checked    (checked),
    .hits       (hits),
    .refused    (refused)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic tst_pkg::in_t make_word(input logic [1:0] cmd, input logic [31:0] key,
                                             input logic [31:0] content);
    tst_pkg::in_t w;
    w.cmd = cmd;
    w.key = key;
    w.content = content;
    return w;
  endfunction

  // Offer one word and hold it until accepted; valid stays high unless a gap is taken.
  task automatic send_word(input tst_pkg::in_t w);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(posedge clk);
    end while (in_stall);
    if (w.cmd != CMD_UNUSED) sent++;
    idle_on = !(sent >= QUIET_FROM && sent < QUIET_TO);
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && sent >= HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles where neither channel moves a word.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int          pool;
    int          len;
    int          r;
    int          episode;
    logic [31:0] base;
    logic [31:0] key;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extreme keys, transposes, update, clear, unused command
    send_word(make_word(tst_pkg::CMD_SEARCH, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(tst_pkg::CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(make_word(tst_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(make_word(tst_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(tst_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(tst_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000));
    send_word(make_word(tst_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(tst_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000));
    send_word(make_word(tst_pkg::CMD_SEARCH, 32'h8000_0000, 32'h0000_0000));
    send_word(make_word(tst_pkg::CMD_INSERT, 32'h0000_0000, 32'h1234_5678));
    send_word(make_word(tst_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'hDEAD_BEEF));
    send_word(make_word(tst_pkg::CMD_SEARCH, 32'h0000_002A, 32'h0000_0000));
    send_word(make_word(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(tst_pkg::CMD_SEARCH, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(tst_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(tst_pkg::CMD_SEARCH, 32'h8000_0000, 32'h0000_0000));
    send_word(make_word(CMD_UNUSED, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(tst_pkg::CMD_INSERT, 32'h0000_0005, 32'h0000_0001));
    send_word(make_word(tst_pkg::CMD_INSERT, 32'h0000_0005, 32'hFFFF_FFFE));

    // random episodes over a small key pool so hits, moves and a full table are common
    episode = 0;
    while (sent < TARGET_ITEMS) begin
      pool = (episode == 0) ? 40 : $urandom_range(1, 40);
      len  = (episode == 0) ? 90 : $urandom_range(15, 60);
      base = $urandom;
      send_word(make_word(tst_pkg::CMD_CLEAR, $urandom, $urandom));
      for (int j = 0; j < len; j++) begin
        r = $urandom_range(99);
        key = base + $urandom_range(0, pool - 1);
        if (episode == 0 && r < 80)
          send_word(make_word(tst_pkg::CMD_INSERT, key, $urandom));
        else if (r < 45)
          send_word(make_word(tst_pkg::CMD_INSERT, key, $urandom));
        else if (r < 88)
          send_word(make_word(tst_pkg::CMD_SEARCH, key, $urandom));
        else if (r < 93)
          send_word(make_word(($urandom_range(1) ? tst_pkg::CMD_SEARCH : tst_pkg::CMD_INSERT),
                              $urandom, $urandom));
        else if (r < 97)
          send_word(make_word(CMD_UNUSED, $urandom, $urandom));
        else
          send_word(make_word(tst_pkg::CMD_CLEAR, $urandom, $urandom));
      end
      episode++;
    end
    in_valid <= 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands in %0d table episodes; %0d result words checked,", sent,
             episode, checked);
    $display("  %0d hits, %0d inserts refused on a full table, one %0d-cycle output hold-off",
             hits, refused, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
